// ===== src/dth_pkg.sv =====
// ----------------------------------------------------------------------------
// dth_pkg: shared types and constants of the deadline timer heap
// entry layout, controller states and the command / status bundles
// ----------------------------------------------------------------------------
package dth_pkg;

  localparam int unsigned HEAP_DEPTH = 16;
  localparam int unsigned ID_BITS    = 8;
  localparam int unsigned IDX_W      = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CMP_W      = IDX_W + 2;
  localparam int unsigned NS_W       = 63;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned NSMS_W     = 20;
  localparam int unsigned PROD_W     = MS_W + NSMS_W;

  localparam logic [NSMS_W-1:0] NsPerMs = NSMS_W'(1000000);

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TICK = 1'b1
  } dth_action_e;

  typedef struct packed {
    logic [NS_W-1:0]    deadline;
    logic [MS_W-1:0]    interval;
    logic [ID_BITS-1:0] task_id;
    logic               repeat_en;
  } dth_entry_t;

  localparam int unsigned ENTRY_W = $bits(dth_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_TCHK,
    ST_RLAST,
    ST_DN,
    ST_DNL,
    ST_DNR,
    ST_MUL,
    ST_ADD,
    ST_UP,
    ST_UPW,
    ST_FIN,
    ST_OUT
  } dth_state_e;

  typedef enum logic [2:0] {
    RA_ZERO,
    RA_LAST,
    RA_LEFT,
    RA_RIGHT,
    RA_PARENT
  } dth_rd_sel_e;

  typedef enum logic [1:0] {
    WD_CUR,
    WD_LV,
    WD_RDATA
  } dth_wr_sel_e;

  typedef enum logic [2:0] {
    IX_KEEP,
    IX_ZERO,
    IX_LEFT,
    IX_RIGHT,
    IX_PARENT,
    IX_COUNT
  } dth_idx_sel_e;

  typedef struct packed {
    logic         ld_in;
    logic         rd_en;
    dth_rd_sel_e  rd_sel;
    logic         wr_en;
    dth_wr_sel_e  wr_sel;
    dth_idx_sel_e idx_sel;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         set_fire;
    logic         ld_cur_rd;
    logic         ld_cur_new;
    logic         ld_lv;
    logic         set_ovf;
    logic         ld_out;
  } dth_cmd_t;

  typedef struct packed {
    logic action;
    logic cnt_zero;
    logic cnt_full;
    logic cnt_one;
    logic due;
    logic l_ok;
    logic r_ok;
    logic rd_lt_cur;
    logic lv_lt_cur;
    logic r_win;
    logic cur_lt_rd;
    logic pop_rep;
    logic rd_rep;
    logic idx_zero;
  } dth_stat_t;

endpackage

// ===== src/dth_if.sv =====
// ----------------------------------------------------------------------------
// dth_in_if / dth_out_if: request and result channels
// valid / ready handshake with the payload fields
// ----------------------------------------------------------------------------
interface dth_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [62:0] now_ns;
  logic [7:0]  task_id;
  logic [31:0] interval_ms;
  logic        periodic;
  modport source (output valid, action, now_ns, task_id, interval_ms, periodic, input ready);
  modport sink   (input valid, action, now_ns, task_id, interval_ms, periodic, output ready);
endinterface

interface dth_out_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [7:0]  fired_id;
  logic        next_valid;
  logic [62:0] next_deadline_ns;
  logic [4:0]  entry_count;
  logic        overflow;
  modport source (output valid, fired, fired_id, next_valid, next_deadline_ns, entry_count,
                  overflow, input ready);
  modport sink   (input valid, fired, fired_id, next_valid, next_deadline_ns, entry_count,
                  overflow, output ready);
endinterface

// ===== src/dth_ram.sv =====
// ----------------------------------------------------------------------------
// dth_ram: generic single write, single read ram
// registered read data, held while no read is issued
// ----------------------------------------------------------------------------
module dth_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dth_datapath.sv =====
// ----------------------------------------------------------------------------
// dth_datapath: heap storage, sift registers and deadline arithmetic
// carries out the controller commands and reports compare status
// ----------------------------------------------------------------------------
module dth_datapath
  import dth_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dth_cmd_t          cmd_i,
  output dth_stat_t         stat_o,
  input  logic              in_action_i,
  input  logic [NS_W-1:0]   in_now_i,
  input  logic [7:0]        in_task_i,
  input  logic [MS_W-1:0]   in_ms_i,
  input  logic              in_rep_i,
  output logic              fired_o,
  output logic [7:0]        fired_id_o,
  output logic              next_valid_o,
  output logic [NS_W-1:0]   next_deadline_o,
  output logic [4:0]        entry_count_o,
  output logic              overflow_o
);

  logic               action_q;
  logic [NS_W-1:0]    now_q;
  logic [ID_BITS-1:0] task_q;
  logic [MS_W-1:0]    ms_q;
  logic               rep_q;
  dth_entry_t         cur_q, lv_q, pop_q, rdata, wdata, new_entry;
  logic [PROD_W-1:0]  prod_q;
  logic [IDX_W-1:0]   idx_q, idx_d, raddr;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               fired_q, ovf_q;
  logic [CMP_W-1:0]   left_w, right_w, parent_w, cnt_w;
  logic [NS_W-1:0]    base;
  logic [NS_W:0]      sum;
  logic               fired_r, next_valid_r, ovf_r;
  logic [7:0]         fired_id_r;
  logic [NS_W-1:0]    next_dl_r;
  logic [4:0]         count_r;

  assign left_w   = CMP_W'({idx_q, 1'b1});
  assign right_w  = left_w + CMP_W'(1);
  assign parent_w = (CMP_W'(idx_q) - CMP_W'(1)) >> 1;
  assign cnt_w    = CMP_W'(cnt_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RA_ZERO:   raddr = '0;
      RA_LAST:   raddr = IDX_W'(cnt_q - CNT_W'(1));
      RA_LEFT:   raddr = left_w[IDX_W-1:0];
      RA_RIGHT:  raddr = right_w[IDX_W-1:0];
      RA_PARENT: raddr = parent_w[IDX_W-1:0];
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WD_CUR:   wdata = cur_q;
      WD_LV:    wdata = lv_q;
      WD_RDATA: wdata = rdata;
      default:  wdata = cur_q;
    endcase
  end

  dth_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HEAP_DEPTH)
  ) u_heap (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(idx_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // deadline = base + interval * 1e6, saturated to 63 bits
  assign base = action_q ? pop_q.deadline : now_q;
  assign sum  = {1'b0, base} + (NS_W + 1)'(prod_q);

  always_comb begin
    new_entry.deadline  = sum[NS_W] ? {NS_W{1'b1}} : sum[NS_W-1:0];
    new_entry.interval  = action_q ? pop_q.interval : ms_q;
    new_entry.task_id   = action_q ? pop_q.task_id : task_q;
    new_entry.repeat_en = action_q ? pop_q.repeat_en : rep_q;
  end

  always_comb begin
    case (cmd_i.idx_sel)
      IX_KEEP:   idx_d = idx_q;
      IX_ZERO:   idx_d = '0;
      IX_LEFT:   idx_d = left_w[IDX_W-1:0];
      IX_RIGHT:  idx_d = right_w[IDX_W-1:0];
      IX_PARENT: idx_d = parent_w[IDX_W-1:0];
      IX_COUNT:  idx_d = cnt_q[IDX_W-1:0];
      default:   idx_d = idx_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fired_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.ld_in) begin
        fired_q <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        if (cmd_i.set_fire) fired_q <= 1'b1;
        if (cmd_i.set_ovf)  ovf_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      action_q <= in_action_i;
      now_q    <= in_now_i;
      task_q   <= in_task_i[ID_BITS-1:0];
      ms_q     <= in_ms_i;
      rep_q    <= in_rep_i;
    end
    prod_q <= (action_q ? pop_q.interval : ms_q) * NsPerMs;
    idx_q  <= idx_d;
    if (cmd_i.set_fire)   pop_q <= rdata;
    if (cmd_i.ld_lv)      lv_q  <= rdata;
    if (cmd_i.ld_cur_rd)  cur_q <= rdata;
    if (cmd_i.ld_cur_new) cur_q <= new_entry;
    if (cmd_i.ld_out) begin
      fired_r      <= fired_q;
      fired_id_r   <= fired_q ? 8'(pop_q.task_id) : 8'd0;
      next_valid_r <= (cnt_q != '0);
      next_dl_r    <= (cnt_q != '0) ? rdata.deadline : '0;
      count_r      <= 5'(cnt_q);
      ovf_r        <= ovf_q;
    end
  end

  always_comb begin
    stat_o.action    = action_q;
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.cnt_full  = (cnt_q == CNT_W'(HEAP_DEPTH));
    stat_o.cnt_one   = (cnt_q == CNT_W'(1));
    stat_o.due       = (rdata.deadline <= now_q);
    stat_o.l_ok      = (left_w < cnt_w);
    stat_o.r_ok      = (right_w < cnt_w);
    stat_o.rd_lt_cur = (rdata.deadline < cur_q.deadline);
    stat_o.lv_lt_cur = (lv_q.deadline < cur_q.deadline);
    stat_o.r_win     = (rdata.deadline < lv_q.deadline) && (rdata.deadline < cur_q.deadline);
    stat_o.cur_lt_rd = (cur_q.deadline < rdata.deadline);
    stat_o.pop_rep   = pop_q.repeat_en;
    stat_o.rd_rep    = rdata.repeat_en;
    stat_o.idx_zero  = (idx_q == '0);
  end

  assign fired_o         = fired_r;
  assign fired_id_o      = fired_id_r;
  assign next_valid_o    = next_valid_r;
  assign next_deadline_o = next_dl_r;
  assign entry_count_o   = count_r;
  assign overflow_o      = ovf_r;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_cnt_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.cnt_inc && cmd_i.cnt_dec))
    else $error("count incremented and decremented together");

  a_wr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (CNT_W'(idx_q) < cnt_q))
    else $error("heap write outside live slots");

endmodule

// ===== src/dth_ctrl.sv =====
// ----------------------------------------------------------------------------
// dth_ctrl: sequencer of the deadline timer heap
// steps add, pop, sift-down and sift-up and owns the result valid
// ----------------------------------------------------------------------------
module dth_ctrl
  import dth_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dth_stat_t stat_i,
  output dth_cmd_t  cmd_o
);

  dth_state_e state_q, state_d;
  logic       out_valid_q;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (stat_i.action == ACT_ADD) begin
          state_d = stat_i.cnt_full ? ST_FIN : ST_MUL;
        end else begin
          state_d = stat_i.cnt_zero ? ST_FIN : ST_TCHK;
        end
      end
      ST_TCHK: begin
        if (!stat_i.due) begin
          state_d = ST_FIN;
        end else if (stat_i.cnt_one) begin
          // popped entry is still on the read port here
          state_d = stat_i.rd_rep ? ST_MUL : ST_FIN;
        end else begin
          state_d = ST_RLAST;
        end
      end
      ST_RLAST:  state_d = ST_DN;
      ST_DN: begin
        if (stat_i.l_ok) begin
          state_d = ST_DNL;
        end else begin
          state_d = stat_i.pop_rep ? ST_MUL : ST_FIN;
        end
      end
      ST_DNL: begin
        if (stat_i.r_ok) begin
          state_d = ST_DNR;
        end else if (stat_i.rd_lt_cur) begin
          state_d = ST_DN;
        end else begin
          state_d = stat_i.pop_rep ? ST_MUL : ST_FIN;
        end
      end
      ST_DNR: begin
        if (stat_i.r_win || stat_i.lv_lt_cur) begin
          state_d = ST_DN;
        end else begin
          state_d = stat_i.pop_rep ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL:    state_d = ST_ADD;
      ST_ADD:    state_d = ST_UP;
      ST_UP:     state_d = stat_i.idx_zero ? ST_FIN : ST_UPW;
      ST_UPW:    state_d = stat_i.cur_lt_rd ? ST_UP : ST_FIN;
      ST_FIN:    state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel  = RA_ZERO;
    cmd_o.wr_sel  = WD_CUR;
    cmd_o.idx_sel = IX_KEEP;
    case (state_q)
      ST_IDLE:   cmd_o.ld_in = in_valid_i;
      ST_DECIDE: begin
        if (stat_i.action == ACT_ADD) begin
          cmd_o.set_ovf = stat_i.cnt_full;
        end else begin
          cmd_o.rd_en = !stat_i.cnt_zero;
        end
      end
      ST_TCHK: begin
        if (stat_i.due) begin
          cmd_o.set_fire = 1'b1;
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.rd_en    = !stat_i.cnt_one;
          cmd_o.rd_sel   = RA_LAST;
        end
      end
      ST_RLAST: begin
        cmd_o.ld_cur_rd = 1'b1;
        cmd_o.idx_sel   = IX_ZERO;
      end
      ST_DN: begin
        if (stat_i.l_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_LEFT;
        end else begin
          cmd_o.wr_en = 1'b1;
        end
      end
      ST_DNL: begin
        cmd_o.ld_lv = 1'b1;
        if (stat_i.r_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_RIGHT;
        end else if (stat_i.rd_lt_cur) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WD_RDATA;
          cmd_o.idx_sel = IX_LEFT;
        end else begin
          cmd_o.wr_en = 1'b1;
        end
      end
      ST_DNR: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.r_win) begin
          cmd_o.wr_sel  = WD_RDATA;
          cmd_o.idx_sel = IX_RIGHT;
        end else if (stat_i.lv_lt_cur) begin
          cmd_o.wr_sel  = WD_LV;
          cmd_o.idx_sel = IX_LEFT;
        end
      end
      ST_ADD: begin
        cmd_o.ld_cur_new = 1'b1;
        cmd_o.idx_sel    = IX_COUNT;
        cmd_o.cnt_inc    = 1'b1;
      end
      ST_UP: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_en = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_PARENT;
        end
      end
      ST_UPW: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.cur_lt_rd) begin
          cmd_o.wr_sel  = WD_RDATA;
          cmd_o.idx_sel = IX_PARENT;
        end
      end
      ST_FIN:    cmd_o.rd_en = 1'b1;
      ST_OUT:    cmd_o.ld_out = out_free;
      default:   cmd_o = cmd_o;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> out_free)
    else $error("result loaded over a pending result");

  a_out_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> state_q == ST_IDLE)
    else $error("sequencer stuck after result");

  a_fire_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_fire |-> (state_q == ST_TCHK && !stat_i.cnt_zero))
    else $error("fire without a pending task");

endmodule

// ===== src/deadline_timer_heap.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_heap: multi-timer scheduler on a binary min-heap
// add and tick requests; one result per request with fired task and next deadline
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | payload
//  req_i    | in  | valid/ready | action, now_ns, task_id, interval_ms, periodic
//  res_o    | out | valid/ready | fired, fired_id, next_valid, next_deadline_ns,
//           |     |             | entry_count, overflow
//
//  one request at a time, stepped through the sequencer states up to the result load
//  add: interval product, sum, then sift up level by level; an add to a full heap only sets overflow
//  tick: an empty heap, a root not yet due or a one-shot last task firing go straight to the result;
//  a pop moves the last entry to the root and sifts it down, a periodic re-arm then sifts up
//  reset clears the entry count; heap slots are never cleared, only live ones read
//  a stalled result sits in the output register; the next request is taken meanwhile
// ----------------------------------------------------------------------------
module deadline_timer_heap
  import dth_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dth_in_if.sink    req_i,
  dth_out_if.source res_o
);

  dth_cmd_t  cmd;
  dth_stat_t stat;

  // sequencer: steps each request through the heap
  dth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(res_o.valid),
    .out_ready_i(res_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // heap ram, sift registers, deadline arithmetic and result register
  dth_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_action_i    (req_i.action),
    .in_now_i       (req_i.now_ns),
    .in_task_i      (req_i.task_id),
    .in_ms_i        (req_i.interval_ms),
    .in_rep_i       (req_i.periodic),
    .fired_o        (res_o.fired),
    .fired_id_o     (res_o.fired_id),
    .next_valid_o   (res_o.next_valid),
    .next_deadline_o(res_o.next_deadline_ns),
    .entry_count_o  (res_o.entry_count),
    .overflow_o     (res_o.overflow)
  );

endmodule
